// ----- hdl/mse_pkg.sv -----
// Shared types and constants for the smooth escape-time pixel engine.
// No dependencies; imported by every module of the block.
package mse_pkg;

  localparam int FRAC_BITS = 28;   // fraction bits of c and z
  localparam int Q16_ONE   = 65536;
  localparam int REG_W     = 32;
  localparam int IDX_W     = 3;
  localparam int TW        = 35;   // width of the signed log argument t

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_RE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP_IM      = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTER_RE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTER_IM    = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_ITER     = 3'd6;

  // operand choice for the shared log2 unit
  localparam logic [1:0] LOG_SUM = 2'd0;
  localparam logic [1:0] LOG_L1V = 2'd1;
  localparam logic [1:0] LOG_T   = 2'd2;
  localparam logic [1:0] LOG_MAX = 2'd3;

  typedef struct packed {
    logic        [13:0] image_width;
    logic        [13:0] image_height;
    logic        [30:0] step_re;
    logic        [30:0] step_im;
    logic signed [31:0] center_re;
    logic signed [31:0] center_im;
    logic        [15:0] max_iterations;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       cmul;
    logic       cadd;
    logic       mul;
    logic       step;
    logic       sq_start;
    logic       log_start;
    logic [1:0] log_sel;
    logic       div_start;
    logic       set_full;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic esc_now;
    logic lim_now;
    logic sq_done;
    logic log_done;
    logic div_done;
    logic t_pos;
    logic num_pos;
    logic den_pos;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/mandelbrot_smooth_escape.sv -----
// Top level of the smooth escape-time pixel engine: configuration
// registers, sequencer and datapath. Uses mse_pkg, mse_ctrl, mse_datapath.
//
// Input channel: pixel_col/pixel_row with in_valid/in_stall; a transaction
// takes place when in_valid is high and in_stall low. One pixel is worked
// on at a time; in_stall is low only while the engine is idle.
// Output channel: brightness, iteration_count, inside_set with
// out_valid/out_stall. The result sits in an output register, so the next
// pixel is taken while a result still waits; a stalled result holds, and
// the engine stops before writing the following one until it is taken.
// Per pixel: setup states load, c multiply and c add, then a multiply
// state and an update/test state for each iteration of z = z*z + c,
// repeated until max_iterations for pixels inside the set.
// An escaped pixel adds the colouring pass: the bit-serial |z|^2, up to
// four runs of the log2 unit (normalising one bit a cycle, then 16
// squarings) and a restoring divider, then the output step.
// Configuration is written on cfg_we through cfg_index/cfg_data; the
// user must do so only while idle; the block has no check for it.
// Synchronous reset loads the default view and empties both channels.
module mandelbrot_smooth_escape #(
  parameter int ITER_BITS  = 16,
  parameter int COORD_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic [COORD_BITS-1:0] pixel_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            brightness,
  output logic [ITER_BITS-1:0]  iteration_count,
  output logic                  inside_set,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import mse_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= 14'd6000;
      cfg.image_height   <= 14'd4000;
      cfg.step_re        <= 31'd134218;
      cfg.step_im        <= 31'd134218;
      cfg.center_re      <= -32'sd134217728;
      cfg.center_im      <= '0;
      cfg.max_iterations <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width    <= cfg_data[13:0];
        REG_IMAGE_HEIGHT: cfg.image_height   <= cfg_data[13:0];
        REG_STEP_RE:      cfg.step_re        <= cfg_data[30:0];
        REG_STEP_IM:      cfg.step_im        <= cfg_data[30:0];
        REG_CENTER_RE:    cfg.center_re      <= $signed(cfg_data);
        REG_CENTER_IM:    cfg.center_im      <= $signed(cfg_data);
        REG_MAX_ITER:     cfg.max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  mse_datapath #(
    .ITER_BITS  (ITER_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .st              (st),
    .pixel_col       (pixel_col),
    .pixel_row       (pixel_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .brightness      (brightness),
    .iteration_count (iteration_count),
    .inside_set      (inside_set)
  );

endmodule

// ----- hdl/mse_log2.sv -----
// Iterative base-2 logarithm, 16 fraction bits, truncated.
// Normalises one bit a cycle, then 16 mantissa squarings. Uses mse_pkg.
module mse_log2 #(
  parameter int LW = 64,
  localparam int PW = $clog2(LW)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [LW-1:0] opnd,
  output logic          done,
  output logic [PW+15:0] res
);
  import mse_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQR  = 2'd2;

  logic [1:0]    phase;
  logic [LW-1:0] v;
  logic [PW-1:0] p;
  logic [31:0]   m;
  logic [15:0]   frac;
  logic [3:0]    cnt;
  logic [63:0]   sq;
  logic [32:0]   q33;
  logic [15:0]   frac_next;

  assign sq        = m * m;
  assign q33       = sq[63:31];
  assign frac_next = {frac[14:0], q33[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            v     <= opnd;
            p     <= PW'(LW - 1);
            phase <= PH_NORM;
          end
        end
        PH_NORM: begin
          if (v == '0) begin
            res   <= '0;
            done  <= 1'b1;
            phase <= PH_IDLE;
          end else if (v[LW-1]) begin
            m     <= v[LW-1 -: 32];
            frac  <= '0;
            cnt   <= '0;
            phase <= PH_SQR;
          end else begin
            v <= v << 1;
            p <= p - 1'b1;
          end
        end
        PH_SQR: begin
          m    <= q33[32] ? q33[32:1] : q33[31:0];
          frac <= frac_next;
          cnt  <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            res   <= {p, frac_next};
            done  <= 1'b1;
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/mse_datapath.sv -----
// Datapath: pixel mapping, z iteration, escape magnitude, logs, divider
// and output register. Uses mse_pkg and mse_log2; driven by mse_ctrl.
module mse_datapath #(
  parameter int ITER_BITS  = 16,
  parameter int COORD_BITS = 13
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mse_pkg::cfg_t           cfg,
  input  mse_pkg::cmd_t           cmd,
  output mse_pkg::status_t        st,
  input  logic [COORD_BITS-1:0]   pixel_col,
  input  logic [COORD_BITS-1:0]   pixel_row,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              brightness,
  output logic [ITER_BITS-1:0]    iteration_count,
  output logic                    inside_set
);
  import mse_pkg::*;

  localparam int DW   = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
  localparam int PRW  = DW + 32;
  localparam int CW   = PRW + 1;
  localparam int MW   = FRAC_BITS + 2;
  localparam int SQW  = 2 * MW;
  localparam int SRW  = SQW - FRAC_BITS;
  localparam int ZW   = ((CW > SRW + 1) ? CW : SRW + 1) + 1;
  localparam int LW0  = 2 * ZW + 1;
  localparam int LW   = (LW0 > TW) ? LW0 : TW;
  localparam int PW   = $clog2(LW);
  localparam int LOGW = PW + 16;
  localparam int NW   = LOGW + 8;
  localparam int SCW  = $clog2(ZW);
  localparam int DCW  = $clog2(NW);

  localparam logic [ZW-1:0]  MAG_LIM = ZW'(1) << (FRAC_BITS + 1);
  localparam logic [SQW:0]   THR     = (SQW + 1)'(1) << (2 * FRAC_BITS + 2);

  logic [COORD_BITS-1:0] col_r, row_r;
  logic signed [DW-1:0]  dx_re, dx_im;
  logic signed [PRW-1:0] prod_re, prod_im;
  logic signed [CW-1:0]  cr, ci;
  logic signed [ZW-1:0]  zr, zi;
  logic [15:0]           k, iter;
  logic                  escaped;

  logic [ZW-1:0]  mag_zr, mag_zi;
  logic [MW-1:0]  mr, mi;
  logic [SQW-1:0] rr, ii, ri, rr_p, ii_p, ri_p;
  logic           big;
  logic [SQW:0]   sum_sq;
  logic [SRW-1:0] sr, si;
  logic [SRW:0]   x2;
  logic signed [ZW-1:0] sr_s, si_s, x_s, nr, ni;
  logic           flip;

  logic [2*ZW-1:0] sq_a;
  logic [ZW-1:0]   sq_b;
  logic [LW-1:0]   sq_acc;
  logic [SCW-1:0]  sq_cnt;
  logic            sq_pass, sq_busy, sq_done;

  logic [LW-1:0]          lg_opnd;
  logic                   lg_done;
  logic [LOGW-1:0]        lres;
  logic signed [LOGW:0]   lres_s, half, ll, num;
  logic [LOGW-1:0]        l1v, den;
  logic signed [TW-1:0]   t_val;

  logic [NW-1:0]   dv_q;
  logic [LOGW:0]   dv_rem, rem_sh;
  logic [DCW-1:0]  dv_cnt;
  logic            dv_busy, dv_done, dv_ge;
  logic [7:0]      bright;

  // pixel to c
  assign dx_re = $signed({{(DW-COORD_BITS){1'b0}}, col_r})
               - $signed({{(DW-13){1'b0}}, cfg.image_width[13:1]});
  assign dx_im = $signed({{(DW-COORD_BITS){1'b0}}, row_r})
               - $signed({{(DW-13){1'b0}}, cfg.image_height[13:1]});

  // iteration
  assign mag_zr = zr[ZW-1] ? ZW'(-zr) : ZW'(zr);
  assign mag_zi = zi[ZW-1] ? ZW'(-zi) : ZW'(zi);
  assign mr     = mag_zr[MW-1:0];
  assign mi     = mag_zi[MW-1:0];
  assign rr_p   = mr * mr;
  assign ii_p   = mi * mi;
  assign ri_p   = mr * mi;
  assign sum_sq = {1'b0, rr} + {1'b0, ii};
  assign sr     = rr[SQW-1:FRAC_BITS];
  assign si     = ii[SQW-1:FRAC_BITS];
  assign x2     = {ri[SQW-1:FRAC_BITS], 1'b0};
  assign sr_s   = $signed(ZW'(sr));
  assign si_s   = $signed(ZW'(si));
  assign x_s    = $signed(ZW'(x2));
  assign flip   = zr[ZW-1] ^ zi[ZW-1];
  assign nr     = sr_s - si_s + ZW'(cr);
  assign ni     = (flip ? -x_s : x_s) + ZW'(ci);

  // smooth colouring terms
  assign lres_s = $signed({1'b0, lres});
  assign half   = (lres_s - (LOGW + 1)'(2 * FRAC_BITS * Q16_ONE)) >>> 1;
  assign t_val  = $signed(TW'(32'd114688)) + $signed(TW'({iter, 16'h0000})) - TW'(ll);

  always_comb begin
    unique case (cmd.log_sel)
      LOG_SUM: lg_opnd = sq_acc;
      LOG_L1V: lg_opnd = LW'(l1v);
      LOG_T:   lg_opnd = LW'($unsigned(t_val));
      LOG_MAX: lg_opnd = LW'(cfg.max_iterations);
      default: lg_opnd = sq_acc;
    endcase
  end

  assign rem_sh = {dv_rem[LOGW-1:0], dv_q[NW-1]};
  assign dv_ge  = rem_sh >= {1'b0, den};

  assign st.esc_now  = (k != '0) && (big || (sum_sq > THR));
  assign st.lim_now  = (k == cfg.max_iterations);
  assign st.sq_done  = sq_done;
  assign st.log_done = lg_done;
  assign st.div_done = dv_done;
  assign st.t_pos    = !t_val[TW-1] && (t_val != '0);
  assign st.num_pos  = !num[LOGW] && (num != '0);
  assign st.den_pos  = (den != '0);
  assign st.out_free = !out_valid || !out_stall;

  mse_log2 #(.LW(LW)) u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.log_start),
    .opnd  (lg_opnd),
    .done  (lg_done),
    .res   (lres)
  );

  // mapping and iteration registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= pixel_col;
      row_r <= pixel_row;
    end
    if (cmd.cmul) begin
      prod_re <= dx_re * $signed({1'b0, cfg.step_re});
      prod_im <= dx_im * $signed({1'b0, cfg.step_im});
    end
    if (cmd.cadd) begin
      cr      <= CW'(prod_re) + CW'(cfg.center_re);
      ci      <= CW'(prod_im) + CW'(cfg.center_im);
      zr      <= '0;
      zi      <= '0;
      k       <= '0;
      escaped <= 1'b0;
    end
    if (cmd.mul) begin
      rr  <= rr_p;
      ii  <= ii_p;
      ri  <= ri_p;
      big <= (mag_zr > MAG_LIM) || (mag_zi > MAG_LIM);
    end
    if (cmd.step) begin
      if (st.esc_now) begin
        escaped <= 1'b1;
        iter    <= k - 1'b1;
      end else if (!st.lim_now) begin
        zr <= nr;
        zi <= ni;
        k  <= k + 1'b1;
      end
    end
  end

  // |z|^2 by shift and add, real part then imaginary part
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sq_start) begin
        sq_busy <= 1'b1;
        sq_pass <= 1'b0;
        sq_cnt  <= '0;
        sq_acc  <= '0;
        sq_a    <= (2 * ZW)'(mag_zr);
        sq_b    <= mag_zr;
      end else if (sq_busy) begin
        if (sq_b[0]) sq_acc <= sq_acc + LW'(sq_a);
        sq_a   <= sq_a << 1;
        sq_b   <= sq_b >> 1;
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == SCW'(ZW - 1)) begin
          if (!sq_pass) begin
            sq_pass <= 1'b1;
            sq_cnt  <= '0;
            sq_a    <= (2 * ZW)'(mag_zi);
            sq_b    <= mag_zi;
          end else begin
            sq_busy <= 1'b0;
            sq_done <= 1'b1;
          end
        end
      end
    end
  end

  // log results
  always_ff @(posedge clk) begin
    if (lg_done) begin
      unique case (cmd.log_sel)
        LOG_SUM: l1v <= (half < $signed((LOGW + 1)'(Q16_ONE))) ?
                        LOGW'(Q16_ONE) : half[LOGW-1:0];
        LOG_L1V: ll  <= lres_s - (LOGW + 1)'(16 * Q16_ONE);
        LOG_T:   num <= lres_s - (LOGW + 1)'(16 * Q16_ONE);
        LOG_MAX: den <= lres;
        default: den <= lres;
      endcase
    end
  end

  // restoring divider for 256*num/den
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else begin
      dv_done <= 1'b0;
      if (cmd.div_start) begin
        dv_q    <= {num[LOGW-1:0], 8'h00};
        dv_rem  <= '0;
        dv_cnt  <= '0;
        dv_busy <= 1'b1;
      end else if (dv_busy) begin
        dv_rem <= dv_ge ? (rem_sh - {1'b0, den}) : rem_sh;
        dv_q   <= {dv_q[NW-2:0], dv_ge};
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_cnt == DCW'(NW - 1)) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cadd) bright <= '0;
    else if (cmd.set_full) bright <= 8'hFF;
    else if (dv_done) bright <= (dv_q > NW'(255)) ? 8'hFF : dv_q[7:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      brightness      <= bright;
      iteration_count <= ITER_BITS'(escaped ? iter : cfg.max_iterations);
      inside_set      <= !escaped;
    end
  end

endmodule

// ----- hdl/mse_ctrl.sv -----
// Sequencer for the pixel engine: setup, iteration loop, colouring steps.
// Uses mse_pkg; issues commands to mse_datapath and reads its status.
module mse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output mse_pkg::cmd_t    cmd,
  input  mse_pkg::status_t st
);
  import mse_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CMUL     = 4'd1;
  localparam logic [3:0] S_CADD     = 4'd2;
  localparam logic [3:0] S_MUL      = 4'd3;
  localparam logic [3:0] S_STEP     = 4'd4;
  localparam logic [3:0] S_SQ       = 4'd5;
  localparam logic [3:0] S_LOG_GO   = 4'd6;
  localparam logic [3:0] S_LOG_WAIT = 4'd7;
  localparam logic [3:0] S_DIV_GO   = 4'd8;
  localparam logic [3:0] S_DIV_WAIT = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] sel, sel_next;

  always_comb begin
    cmd         = '0;
    cmd.log_sel = sel;
    state_next  = state;
    sel_next    = sel;
    in_stall    = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd.cmul   = 1'b1;
        state_next = S_CADD;
      end
      S_CADD: begin
        cmd.cadd   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        priority if (st.esc_now) begin
          cmd.sq_start = 1'b1;
          state_next   = S_SQ;
        end else if (st.lim_now) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MUL;
        end
      end
      S_SQ: begin
        if (st.sq_done) begin
          sel_next   = LOG_SUM;
          state_next = S_LOG_GO;
        end
      end
      S_LOG_GO: begin
        // non-positive t or log2(t) leaves brightness at zero
        priority if (sel == LOG_T && !st.t_pos) begin
          state_next = S_FIN;
        end else if (sel == LOG_MAX && !st.num_pos) begin
          state_next = S_FIN;
        end else begin
          cmd.log_start = 1'b1;
          state_next    = S_LOG_WAIT;
        end
      end
      S_LOG_WAIT: begin
        if (st.log_done) begin
          unique case (sel)
            LOG_SUM: begin sel_next = LOG_L1V; state_next = S_LOG_GO; end
            LOG_L1V: begin sel_next = LOG_T;   state_next = S_LOG_GO; end
            LOG_T:   begin sel_next = LOG_MAX; state_next = S_LOG_GO; end
            LOG_MAX: state_next = S_DIV_GO;
            default: state_next = S_DIV_GO;
          endcase
        end
      end
      S_DIV_GO: begin
        if (!st.den_pos) begin
          cmd.set_full = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (st.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= LOG_SUM;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> st.out_free) else $error("result written over a pending one");

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.cmul, cmd.cadd, cmd.mul, cmd.step, cmd.log_start,
              cmd.div_start, cmd.fin})) else $error("overlapping commands");

  a_esc_to_sq: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && st.esc_now) |=> (state == S_SQ))
    else $error("escape not followed by magnitude pass");

endmodule
